// ===== rtl/hrlp_pkg.sv =====
// Shared types and constants for the HTTP request line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_SPACE   = 3'd1,
    PH_URI     = 3'd2,
    PH_LITERAL = 3'd3,
    PH_MAJOR   = 3'd4,
    PH_MINOR   = 3'd5,
    PH_PARSED  = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] method_chars;
    logic [2:0]  method_len;
    logic        uri_seen;
    logic [2:0]  lit_idx;
    logic [7:0]  major;
    logic [7:0]  minor;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_METHOD, default: '0};

  localparam logic [1:0] STATUS_BUSY   = 2'd0;
  localparam logic [1:0] STATUS_PARSED = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;

  localparam logic [1:0] METHOD_GET   = 2'd0;
  localparam logic [1:0] METHOD_HEAD  = 2'd1;
  localparam logic [1:0] METHOD_OTHER = 2'd2;

  localparam logic [1:0] KIND_V11    = 2'd0;
  localparam logic [1:0] KIND_V10    = 2'd1;
  localparam logic [1:0] KIND_CUSTOM = 2'd2;

  localparam logic [31:0] WORD_GET  = 32'h0047_4554;
  localparam logic [31:0] WORD_HEAD = 32'h4845_4144;

  localparam logic [2:0] LIT_LEN   = 3'd5;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // Bytes of the protocol literal "HTTP/".
  function automatic logic [7:0] lit_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/hrlp_step.sv =====
// Next-state logic of the request line parser for one byte.
`timescale 1ns / 1ps

module hrlp_step #(
  parameter int POSITION_BITS = 16
) (
  input  hrlp_pkg::state_t           cur_i,
  input  logic [POSITION_BITS-1:0]   pos_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       start_req_i,
  output hrlp_pkg::state_t           nxt_o,
  output logic [POSITION_BITS-1:0]   pos_o,
  output logic                       uri_valid_o,
  output logic [7:0]                 uri_byte_o
);

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'd65) && (c <= 8'd90);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // acc * 10 + d, saturating at 255
  function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [3:0] d);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, d};
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  hrlp_pkg::state_t         st;
  logic [POSITION_BITS-1:0] pos_base;
  logic                     consumed;
  logic                     pos_clear;
  logic [2:0]               lit_next;

  assign st       = start_req_i ? hrlp_pkg::STATE_RESET : cur_i;
  assign pos_base = start_req_i ? '0 : pos_i;
  assign lit_next = st.lit_idx + 3'd1;

  // Next state
  always_comb begin
    nxt_o     = st;
    consumed  = 1'b0;
    pos_clear = 1'b0;
    unique case (st.phase)
      hrlp_pkg::PH_METHOD: begin
        if (is_upper(data_byte_i)) begin
          if (st.method_len < 3'd4) begin
            nxt_o.method_chars = {st.method_chars[23:0], data_byte_i};
          end
          if (st.method_len < 3'd5) begin
            nxt_o.method_len = st.method_len + 3'd1;
          end
          consumed = 1'b1;
        end else if (is_ws(data_byte_i)) begin
          nxt_o.phase = hrlp_pkg::PH_SPACE;
          consumed    = 1'b1;
        end else begin
          nxt_o.phase = hrlp_pkg::PH_ERROR;
        end
      end
      hrlp_pkg::PH_SPACE: begin
        if (is_ws(data_byte_i)) begin
          consumed = 1'b1;
        end else if (!st.uri_seen) begin
          nxt_o.uri_seen = 1'b1;
          nxt_o.phase    = hrlp_pkg::PH_URI;
          consumed       = 1'b1;
        end else if (st.lit_idx < hrlp_pkg::LIT_LEN &&
                     data_byte_i == hrlp_pkg::lit_char(st.lit_idx)) begin
          nxt_o.lit_idx = lit_next;
          nxt_o.phase   = (lit_next == hrlp_pkg::LIT_LEN) ? hrlp_pkg::PH_MAJOR
                                                         : hrlp_pkg::PH_LITERAL;
          consumed      = 1'b1;
        end else begin
          nxt_o.phase = hrlp_pkg::PH_ERROR;
        end
      end
      hrlp_pkg::PH_URI: begin
        if (is_ws(data_byte_i)) begin
          nxt_o.phase = hrlp_pkg::PH_SPACE;
        end
        consumed = 1'b1;
      end
      hrlp_pkg::PH_LITERAL: begin
        if (st.lit_idx < hrlp_pkg::LIT_LEN &&
            data_byte_i == hrlp_pkg::lit_char(st.lit_idx)) begin
          nxt_o.lit_idx = lit_next;
          if (lit_next == hrlp_pkg::LIT_LEN) begin
            nxt_o.phase = hrlp_pkg::PH_MAJOR;
          end
          consumed = 1'b1;
        end else begin
          nxt_o.phase = hrlp_pkg::PH_ERROR;
        end
      end
      hrlp_pkg::PH_MAJOR: begin
        if (is_digit(data_byte_i)) begin
          nxt_o.major = add_digit(st.major, data_byte_i[3:0]);
          consumed    = 1'b1;
        end else if (data_byte_i == hrlp_pkg::CHAR_DOT) begin
          nxt_o.phase = hrlp_pkg::PH_MINOR;
          consumed    = 1'b1;
        end else begin
          nxt_o.phase = hrlp_pkg::PH_ERROR;
        end
      end
      hrlp_pkg::PH_MINOR: begin
        if (is_digit(data_byte_i)) begin
          nxt_o.minor = add_digit(st.minor, data_byte_i[3:0]);
          consumed    = 1'b1;
        end else if (data_byte_i == hrlp_pkg::CHAR_LF) begin
          // Unsupported method is reported at offset zero
          if ((st.method_len == 3'd3 && st.method_chars == hrlp_pkg::WORD_GET) ||
              (st.method_len == 3'd4 && st.method_chars == hrlp_pkg::WORD_HEAD)) begin
            nxt_o.phase = hrlp_pkg::PH_PARSED;
          end else begin
            nxt_o.phase = hrlp_pkg::PH_ERROR;
            pos_clear   = 1'b1;
          end
          consumed = 1'b1;
        end else begin
          nxt_o.phase = hrlp_pkg::PH_ERROR;
        end
      end
      hrlp_pkg::PH_PARSED, hrlp_pkg::PH_ERROR: begin
        nxt_o = st;
      end
      default: begin
        nxt_o = st;
      end
    endcase

    if (pos_clear) begin
      pos_o = '0;
    end else if (consumed && nxt_o.phase != hrlp_pkg::PH_ERROR && pos_base != POS_MAX) begin
      pos_o = pos_base + POS_ONE;
    end else begin
      pos_o = pos_base;
    end
  end

  // URI byte output
  always_comb begin
    uri_valid_o = 1'b0;
    if (!is_ws(data_byte_i)) begin
      if (st.phase == hrlp_pkg::PH_URI) begin
        uri_valid_o = 1'b1;
      end else if (st.phase == hrlp_pkg::PH_SPACE && !st.uri_seen) begin
        uri_valid_o = 1'b1;
      end
    end
    uri_byte_o = uri_valid_o ? data_byte_i : 8'h00;
  end

endmodule

// ===== rtl/http_request_line_parser.sv =====
// Top level of the HTTP request line parser: byte in, one result word out per byte.
// Each accepted byte's result word is on the output register in the cycle after it is accepted.
// Throughput: one byte per cycle while in_stall_o is low; the single parse register stage sets the rate.
// A result word held by out_stall_i stalls the input only while the output is full.
// Reset (rst_ni low, asynchronous) drops any pending word and returns to the method phase.
`timescale 1ns / 1ps

module http_request_line_parser #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        uri_valid_o,
  output logic [7:0]  uri_byte_o,
  output logic [1:0]  status_o,
  output logic [1:0]  method_o,
  output logic [7:0]  major_version_o,
  output logic [7:0]  minor_version_o,
  output logic [1:0]  version_kind_o,
  output logic [15:0] error_position_o
);

  // Parse state. The result fields other than the URI byte are a function of this
  // state alone, so the state registers double as the result register.
  hrlp_pkg::state_t         state_q, state_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     uri_valid_q, uri_valid_d;
  logic [7:0]               uri_byte_q, uri_byte_d;
  logic                     out_valid_q;
  logic                     in_accept;
  logic                     method_ok;
  logic [1:0]               method_code;
  logic [POSITION_BITS+15:0] pos_ext;

  // Hold the input while a finished word waits and the sink stalls.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  hrlp_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .cur_i       (state_q),
    .pos_i       (pos_q),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .nxt_o       (state_d),
    .pos_o       (pos_d),
    .uri_valid_o (uri_valid_d),
    .uri_byte_o  (uri_byte_d)
  );

  // Advance the parse state only on an accepted byte; the previous word is taken
  // on that same edge, so the output fields never change under a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrlp_pkg::STATE_RESET;
      pos_q       <= '0;
      uri_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        pos_q       <= pos_d;
        uri_valid_q <= uri_valid_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // URI byte carries no control meaning: no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      uri_byte_q <= uri_byte_d;
    end
  end

  // Method decode from the stored letters and length.
  always_comb begin
    if (state_q.method_len == 3'd3 && state_q.method_chars == hrlp_pkg::WORD_GET) begin
      method_code = hrlp_pkg::METHOD_GET;
    end else if (state_q.method_len == 3'd4 &&
                 state_q.method_chars == hrlp_pkg::WORD_HEAD) begin
      method_code = hrlp_pkg::METHOD_HEAD;
    end else begin
      method_code = hrlp_pkg::METHOD_OTHER;
    end
  end

  assign method_ok = (state_q.phase == hrlp_pkg::PH_PARSED);

  // Widen before taking the low 16 bits so narrow position counters zero-extend.
  assign pos_ext = {16'h0000, pos_q};

  always_comb begin
    status_o         = hrlp_pkg::STATUS_BUSY;
    method_o         = hrlp_pkg::METHOD_OTHER;
    version_kind_o   = hrlp_pkg::KIND_V11;
    error_position_o = 16'h0000;
    if (method_ok) begin
      status_o = hrlp_pkg::STATUS_PARSED;
      method_o = method_code;
      if (state_q.major == 8'd1 && state_q.minor == 8'd1) begin
        version_kind_o = hrlp_pkg::KIND_V11;
      end else if (state_q.major == 8'd1 && state_q.minor == 8'd0) begin
        version_kind_o = hrlp_pkg::KIND_V10;
      end else begin
        version_kind_o = hrlp_pkg::KIND_CUSTOM;
      end
    end else if (state_q.phase == hrlp_pkg::PH_ERROR) begin
      status_o         = hrlp_pkg::STATUS_ERROR;
      error_position_o = pos_ext[15:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign uri_valid_o     = uri_valid_q;
  assign uri_byte_o      = uri_byte_q;
  assign major_version_o = state_q.major;
  assign minor_version_o = state_q.minor;

endmodule

// ===== rtl/hrlp_checker.sv =====
// Port-level checks for the request line parser, bound to its top level.
`timescale 1ns / 1ps

module hrlp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        uri_valid_i,
  input logic [7:0]  uri_byte_i,
  input logic [1:0]  status_i,
  input logic [1:0]  method_i,
  input logic [7:0]  major_version_i,
  input logic [7:0]  minor_version_i,
  input logic [1:0]  version_kind_i,
  input logic [15:0] error_position_i
);

  // A stalled word stays presented.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result word dropped under stall");

  a_method_only_when_parsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != hrlp_pkg::STATUS_PARSED |-> method_i == hrlp_pkg::METHOD_OTHER)
    else $error("method reported before line parsed");

  a_uri_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !uri_valid_i |-> uri_byte_i == 8'h00)
    else $error("uri byte set without uri valid");

  a_epos_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != hrlp_pkg::STATUS_ERROR |-> error_position_i == 16'h0000)
    else $error("error position set outside error status");

  a_kind_matches_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == hrlp_pkg::STATUS_PARSED |->
      ((version_kind_i == hrlp_pkg::KIND_V11) ==
       (major_version_i == 8'd1 && minor_version_i == 8'd1)))
    else $error("version kind disagrees with version digits");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .uri_valid_i      (uri_valid_o),
  .uri_byte_i       (uri_byte_o),
  .status_i         (status_o),
  .method_i         (method_o),
  .major_version_i  (major_version_o),
  .minor_version_i  (minor_version_o),
  .version_kind_i   (version_kind_o),
  .error_position_i (error_position_o)
);
